[rtl/ggw_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ggw_pkg
// Shared constants, types, node tables and per-axis helpers for the GIMP grid
// weight pipeline.
// ----------------------------------------------------------------------------
package ggw_pkg;

  // field widths
  localparam int POS_W      = 18;
  localparam int HALF_W     = 17;
  localparam int IDX_W      = 24;
  localparam int STRIDE_W   = 24;
  localparam int INV_W      = 32;
  localparam int GRAD_W     = 32;
  localparam int WEIGHT_W   = 17;
  localparam int INDEX_BITS = 24;

  // stream and config widths
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 144;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // candidate nodes
  localparam int CAND_NODES = 64;
  localparam int CAND_ID_W  = 6;

  // divider shape: quotient bits, numerator and divisor widths
  localparam int Q_W  = 17;
  localparam int DN_W = 35;
  localparam int DD_W = 20;

  // index sum width, wide enough for any index limit plus sign
  localparam int SUM_W = 36;
  localparam logic [SUM_W-1:0] IDX_LIMIT = SUM_W'(64'd1 << INDEX_BITS);

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INV_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_Z = 3'd5;

  // node offset codes along one axis
  localparam logic [1:0] OFS_M1 = 2'd0;
  localparam logic [1:0] OFS_0  = 2'd1;
  localparam logic [1:0] OFS_P1 = 2'd2;
  localparam logic [1:0] OFS_P2 = 2'd3;

  // candidate order, as offset codes per axis
  localparam logic [1:0] CAND_CX [0:CAND_NODES-1] = '{
    2'd1,2'd2,2'd2,2'd1,2'd1,2'd2,2'd2,2'd1,
    2'd0,2'd1,2'd2,2'd3,2'd3,2'd3,2'd3,2'd2,2'd1,2'd0,2'd0,2'd0,
    2'd0,2'd1,2'd2,2'd3,2'd3,2'd3,2'd3,2'd2,2'd1,2'd0,2'd0,2'd0,
    2'd1,2'd2,2'd2,2'd1,2'd0,2'd1,2'd2,2'd3,2'd3,2'd3,2'd3,2'd2,2'd1,2'd0,2'd0,2'd0,
    2'd1,2'd2,2'd2,2'd1,2'd0,2'd1,2'd2,2'd3,2'd3,2'd3,2'd3,2'd2,2'd1,2'd0,2'd0,2'd0};
  localparam logic [1:0] CAND_CY [0:CAND_NODES-1] = '{
    2'd1,2'd1,2'd2,2'd2,2'd1,2'd1,2'd2,2'd2,
    2'd0,2'd0,2'd0,2'd0,2'd1,2'd2,2'd3,2'd3,2'd3,2'd3,2'd2,2'd1,
    2'd0,2'd0,2'd0,2'd0,2'd1,2'd2,2'd3,2'd3,2'd3,2'd3,2'd2,2'd1,
    2'd1,2'd1,2'd2,2'd2,2'd0,2'd0,2'd0,2'd0,2'd1,2'd2,2'd3,2'd3,2'd3,2'd3,2'd2,2'd1,
    2'd1,2'd1,2'd2,2'd2,2'd0,2'd0,2'd0,2'd0,2'd1,2'd2,2'd3,2'd3,2'd3,2'd3,2'd2,2'd1};
  localparam logic [1:0] CAND_CZ [0:CAND_NODES-1] = '{
    2'd1,2'd1,2'd1,2'd1,2'd2,2'd2,2'd2,2'd2,
    2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,
    2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,
    2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,2'd0,
    2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3};

  // one particle as it enters
  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [HALF_W-1:0]       half_x;
    logic [HALF_W-1:0]       half_y;
    logic [HALF_W-1:0]       half_z;
    logic [IDX_W-1:0]        base;
    logic                    grad;
  } part_t;

  // one candidate node issued by the walker
  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [HALF_W-1:0]       half_x;
    logic [HALF_W-1:0]       half_y;
    logic [HALF_W-1:0]       half_z;
    logic [IDX_W-1:0]        base;
    logic                    grad;
    logic [1:0]              cx;
    logic [1:0]              cy;
    logic [1:0]              cz;
    logic                    last;
  } issue_t;

  // sideband that travels with a node result
  typedef struct packed {
    logic [IDX_W-1:0] node_index;
    logic             bad;
    logic             last;
    logic             grad;
    logic [2:0]       gpos;
  } side_t;

  // signed distance from the node to the particle
  function automatic logic signed [19:0] axis_diff(logic signed [POS_W-1:0] pos,
                                                   logic [1:0] code);
    logic signed [19:0] coord;
    case (code)
      OFS_M1:  coord = -20'sd196608;
      OFS_0:   coord = -20'sd65536;
      OFS_P1:  coord = 20'sd65536;
      default: coord = 20'sd196608;
    endcase
    return {{2{pos[POS_W-1]}}, pos} - coord;
  endfunction

  function automatic logic [18:0] abs_diff(logic signed [19:0] diff);
    return diff[19] ? 19'(-diff) : diff[18:0];
  endfunction

  // half size of zero acts as one lsb, anything above one acts as one
  function automatic logic [HALF_W-1:0] clamp_half(logic [HALF_W-1:0] h);
    if (h == '0) return 17'd1;
    if (h > 17'd65536) return 17'd65536;
    return h;
  endfunction

endpackage
`default_nettype wire

[rtl/ggw_walker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ggw_walker
// Holds one particle, builds the mask of reached candidate nodes and issues
// one reached node per cycle while enabled, in candidate order.
// ----------------------------------------------------------------------------
module ggw_walker (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           s_valid,
  output logic           s_ready,
  input  ggw_pkg::part_t part_in,
  output logic           issue_valid,
  output ggw_pkg::issue_t issue
);
  import ggw_pkg::*;

  logic [CAND_NODES-1:0] mask;
  logic [CAND_NODES-1:0] rest;
  logic [CAND_NODES-1:0] new_mask;
  logic [CAND_ID_W-1:0]  sel;
  logic [3:0]            rx, ry, rz;
  logic [HALF_W-1:0]     hx, hy, hz;
  part_t                 part;
  logic                  accept;

  // clamp half sizes and test reach per axis offset
  always_comb begin
    hx = clamp_half(part_in.half_x);
    hy = clamp_half(part_in.half_y);
    hz = clamp_half(part_in.half_z);
    for (int c = 0; c < 4; c++) begin
      rx[c] = abs_diff(axis_diff(part_in.pos_x, 2'(c))) < (19'd131072 + {2'b00, hx});
      ry[c] = abs_diff(axis_diff(part_in.pos_y, 2'(c))) < (19'd131072 + {2'b00, hy});
      rz[c] = abs_diff(axis_diff(part_in.pos_z, 2'(c))) < (19'd131072 + {2'b00, hz});
    end
    for (int i = 0; i < CAND_NODES; i++) begin
      new_mask[i] = rx[CAND_CX[i]] & ry[CAND_CY[i]] & rz[CAND_CZ[i]];
    end
  end

  // lowest pending candidate
  always_comb begin
    sel = '0;
    for (int i = CAND_NODES - 1; i >= 0; i--) begin
      if (mask[i]) sel = CAND_ID_W'(i);
    end
  end

  assign rest    = mask & (mask - 1'b1);
  assign s_ready = en && (rest == '0);
  assign accept  = s_valid && s_ready;

  // mask and issue valid
  always_ff @(posedge clk) begin
    if (rst) begin
      mask        <= '0;
      issue_valid <= 1'b0;
    end else if (en) begin
      issue_valid <= |mask;
      mask        <= accept ? new_mask : rest;
    end
  end

  // particle hold and issue payload
  always_ff @(posedge clk) begin
    if (en) begin
      issue.pos_x  <= part.pos_x;
      issue.pos_y  <= part.pos_y;
      issue.pos_z  <= part.pos_z;
      issue.half_x <= part.half_x;
      issue.half_y <= part.half_y;
      issue.half_z <= part.half_z;
      issue.base   <= part.base;
      issue.grad   <= part.grad;
      issue.cx     <= CAND_CX[sel];
      issue.cy     <= CAND_CY[sel];
      issue.cz     <= CAND_CZ[sel];
      issue.last   <= (rest == '0);
    end
    if (accept) begin
      part.pos_x  <= part_in.pos_x;
      part.pos_y  <= part_in.pos_y;
      part.pos_z  <= part_in.pos_z;
      part.half_x <= hx;
      part.half_y <= hy;
      part.half_z <= hz;
      part.base   <= part_in.base;
      part.grad   <= part_in.grad;
    end
  end

endmodule
`default_nettype wire

[rtl/ggw_axis.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ggw_axis
// One axis of one node: picks the GIMP region and forms numerator and
// divisor for the weight and for the slope magnitude. Two register stages.
// ----------------------------------------------------------------------------
module ggw_axis (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [ggw_pkg::POS_W-1:0] pos,
  input  logic [ggw_pkg::HALF_W-1:0]       half,
  input  logic [1:0]                       code,
  output logic                             gpos,
  output logic [ggw_pkg::DN_W-1:0]         num_s,
  output logic [ggw_pkg::DD_W-1:0]         den_s,
  output logic [ggw_pkg::DN_W-1:0]         num_g,
  output logic [ggw_pkg::DD_W-1:0]         den_g
);
  import ggw_pkg::*;

  localparam logic [1:0] REG_INNER = 2'd0;
  localparam logic [1:0] REG_MID   = 2'd1;
  localparam logic [1:0] REG_OUTER = 2'd2;

  logic signed [19:0] diff;
  logic [18:0]        d;
  logic [18:0]        l19;
  logic [1:0]         region;
  logic [18:0]        a_full;

  logic [18:0]        a_d;
  logic [17:0]        a_a;
  logic [1:0]         a_reg;
  logic [HALF_W-1:0]  a_l;
  logic               a_gpos;

  logic [35:0]        inner_t;
  logic [35:0]        d_sq;
  logic [35:0]        a_sq;
  logic [DN_W-1:0]    ns, ng;
  logic [DD_W-1:0]    ds, dg;

  // stage a: distance and region
  always_comb begin
    diff   = axis_diff(pos, code);
    d      = abs_diff(diff);
    l19    = {2'b00, half};
    a_full = 19'd131072 + l19 - d;
    if (d < l19) region = REG_INNER;
    else if (d <= 19'd131072 - l19) region = REG_MID;
    else region = REG_OUTER;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_d    <= d;
      a_a    <= a_full[17:0];
      a_reg  <= region;
      a_l    <= half;
      a_gpos <= !diff[19] && (diff != '0);
    end
  end

  // stage b: numerators and divisors per region
  always_comb begin
    inner_t = {17'b0, 19'd262144 - {2'b00, a_l}} * {19'b0, a_l};
    d_sq    = {17'b0, a_d} * {17'b0, a_d};
    a_sq    = {18'b0, a_a} * {18'b0, a_a};
    unique case (a_reg)
      REG_INNER: begin
        ns = DN_W'(inner_t - d_sq);
        ds = DD_W'({a_l, 2'b00});
        ng = DN_W'({a_d, 16'b0});
        dg = DD_W'({a_l, 1'b0});
      end
      REG_MID: begin
        ns = DN_W'(19'd131072 - a_d);
        ds = 20'd2;
        ng = 35'd32768;
        dg = 20'd1;
      end
      REG_OUTER: begin
        ns = DN_W'(a_sq);
        ds = DD_W'({a_l, 3'b000});
        ng = DN_W'({a_a, 16'b0});
        dg = DD_W'({a_l, 2'b00});
      end
      default: begin
        ns = '0;
        ds = 20'd1;
        ng = '0;
        dg = 20'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gpos  <= a_gpos;
      num_s <= ns;
      den_s <= ds;
      num_g <= ng;
      den_g <= dg;
    end
  end

endmodule
`default_nettype wire

[rtl/ggw_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ggw_div
// Pipelined restoring divider, one quotient bit per stage. The numerator is
// known to be below divisor times two to the quotient width.
// ----------------------------------------------------------------------------
module ggw_div (
  input  logic                     clk,
  input  logic                     en,
  input  logic [ggw_pkg::DN_W-1:0] num,
  input  logic [ggw_pkg::DD_W-1:0] den,
  output logic [ggw_pkg::Q_W-1:0]  quo
);
  import ggw_pkg::*;

  logic [DD_W-1:0] rem_r [1:Q_W-1];
  logic [Q_W-1:0]  low_r [1:Q_W-1];
  logic [DD_W-1:0] den_r [1:Q_W-1];
  logic [Q_W-1:0]  quo_r [1:Q_W];

  genvar s;
  generate
    for (s = 0; s < Q_W; s++) begin : g_step
      logic [DD_W-1:0] rem_i, den_i, rem_o;
      logic [Q_W-1:0]  low_i, quo_i, quo_o;
      logic [DD_W:0]   trial, sub;
      logic            ge;

      if (s == 0) begin : g_first
        assign rem_i = DD_W'(num[DN_W-1:Q_W]);
        assign low_i = num[Q_W-1:0];
        assign den_i = den;
        assign quo_i = '0;
      end else begin : g_next
        assign rem_i = rem_r[s];
        assign low_i = low_r[s];
        assign den_i = den_r[s];
        assign quo_i = quo_r[s];
      end

      // trial subtract of one bit
      always_comb begin
        trial = {rem_i, low_i[Q_W-1-s]};
        sub   = trial - {1'b0, den_i};
        ge    = trial >= {1'b0, den_i};
        rem_o = ge ? sub[DD_W-1:0] : trial[DD_W-1:0];
        quo_o = quo_i;
        quo_o[Q_W-1-s] = ge;
      end

      always_ff @(posedge clk) begin
        if (en) quo_r[s+1] <= quo_o;
      end

      if (s < Q_W - 1) begin : g_carry
        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[s+1] <= rem_o;
            low_r[s+1] <= low_i;
            den_r[s+1] <= den_i;
          end
        end
      end
    end
  endgenerate

  assign quo = quo_r[Q_W];

endmodule
`default_nettype wire

[rtl/gimp_grid_weights_3d.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gimp_grid_weights_3d
// GIMP node weights and gradients of one material point on a 3D grid.
// ----------------------------------------------------------------------------
// A particle is taken in one transfer; the block then emits one transfer per
// grid node that the particle's support reaches (at most 27), in fixed
// candidate order, with tlast on the final one. The node walker issues one
// node per cycle while the output is not stalled; the next particle is taken
// as the last node of the current one issues. Results pass through the axis
// stages, the 17-stage divider and the product stages and stream out at one
// per cycle when not stalled. Any output stall holds the whole pipeline.
// Configuration writes take effect at once and are meant for an idle block.
module gimp_grid_weights_3d (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // pos_x, pos_y, pos_z, half_x, half_y, half_z, base_node, want_grad
  input  logic [ggw_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // node_index, index_bad, weight, grad_x, grad_y, grad_z
  output logic [ggw_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic [ggw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ggw_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ggw_pkg::*;

  logic                en;
  logic [INV_W-1:0]    inv_x, inv_y, inv_z;
  logic [STRIDE_W-1:0] stride_x, stride_y, stride_z;

  part_t  part_in;
  logic   v_p1;
  issue_t issue;

  logic             gpos_x, gpos_y, gpos_z;
  logic [DN_W-1:0]  nsx, ngx, nsy, ngy, nsz, ngz;
  logic [DD_W-1:0]  dsx, dgx, dsy, dgy, dsz, dgz;
  logic [Q_W-1:0]   sx, gx, sy, gy, sz, gz;

  logic [SUM_W-1:0] idx_sum;
  logic             idx_bad;
  side_t            side_p1, side_p2, side_p3, side_in;
  logic             v_p2, v_p3;
  logic             v_div [1:Q_W];
  side_t            side_div [1:Q_W];

  logic             v_m1, v_m2, v_m3;
  side_t            side_m1, side_m2, side_m3;
  logic [33:0]      ws_m1, pxa_m1, pya_m1, pza_m1;
  logic [Q_W-1:0]   sy_m1, sz_m1;
  logic [50:0]      w_full, tx_full, ty_full, tz_full;
  logic [WEIGHT_W-1:0] w_m2, w_m3;
  logic [31:0]      tx_m2, ty_m2, tz_m2;
  logic [63:0]      mx_full, my_full, mz_full;
  logic [GRAD_W-1:0] mx_m3, my_m3, mz_m3;

  logic [IDX_W-1:0]    out_index;
  logic                out_bad;
  logic [WEIGHT_W-1:0] out_weight;
  logic [GRAD_W-1:0]   out_gx, out_gy, out_gz;

  // signed index step for one axis offset, two's complement
  function automatic logic [SUM_W-1:0] idx_term(logic [1:0] code,
                                                logic [STRIDE_W-1:0] stride);
    logic [SUM_W-1:0] s;
    s = SUM_W'(stride);
    case (code)
      OFS_M1:  idx_term = ~s + 1'b1;
      OFS_0:   idx_term = '0;
      OFS_P1:  idx_term = s;
      default: idx_term = s << 1;
    endcase
  endfunction

  // sign and saturation of one gradient component
  function automatic logic [GRAD_W-1:0] fin_grad(logic [GRAD_W-1:0] mag,
                                                 logic pos_side, logic want);
    if (!want) return '0;
    if (pos_side) return GRAD_W'(0) - mag;
    if (mag > 32'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return mag;
  endfunction

  // whole pipeline moves unless the output holds a result
  assign en = !m_tvalid || m_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_x    <= 32'd65536;
      inv_y    <= 32'd65536;
      inv_z    <= 32'd65536;
      stride_x <= 24'd1;
      stride_y <= 24'd0;
      stride_z <= 24'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INV_X:    inv_x    <= cfg_data;
        CFG_INV_Y:    inv_y    <= cfg_data;
        CFG_INV_Z:    inv_z    <= cfg_data;
        CFG_STRIDE_X: stride_x <= cfg_data[STRIDE_W-1:0];
        CFG_STRIDE_Y: stride_y <= cfg_data[STRIDE_W-1:0];
        CFG_STRIDE_Z: stride_z <= cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // input unpacking
  assign part_in.pos_x  = s_tdata[17:0];
  assign part_in.pos_y  = s_tdata[35:18];
  assign part_in.pos_z  = s_tdata[53:36];
  assign part_in.half_x = s_tdata[70:54];
  assign part_in.half_y = s_tdata[87:71];
  assign part_in.half_z = s_tdata[104:88];
  assign part_in.base   = s_tdata[128:105];
  assign part_in.grad   = s_tdata[129];

  ggw_walker u_walker (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .s_valid     (s_tvalid),
    .s_ready     (s_tready),
    .part_in     (part_in),
    .issue_valid (v_p1),
    .issue       (issue)
  );

  ggw_axis u_axis_x (
    .clk (clk), .en (en), .pos (issue.pos_x), .half (issue.half_x), .code (issue.cx),
    .gpos (gpos_x), .num_s (nsx), .den_s (dsx), .num_g (ngx), .den_g (dgx)
  );
  ggw_axis u_axis_y (
    .clk (clk), .en (en), .pos (issue.pos_y), .half (issue.half_y), .code (issue.cy),
    .gpos (gpos_y), .num_s (nsy), .den_s (dsy), .num_g (ngy), .den_g (dgy)
  );
  ggw_axis u_axis_z (
    .clk (clk), .en (en), .pos (issue.pos_z), .half (issue.half_z), .code (issue.cz),
    .gpos (gpos_z), .num_s (nsz), .den_s (dsz), .num_g (ngz), .den_g (dgz)
  );

  // node index and range check
  always_comb begin
    idx_sum = SUM_W'(issue.base) + idx_term(issue.cx, stride_x)
            + idx_term(issue.cy, stride_y) + idx_term(issue.cz, stride_z);
    idx_bad = idx_sum[SUM_W-1] || (idx_sum >= IDX_LIMIT);
    side_p1.node_index = idx_bad ? '0 : idx_sum[IDX_W-1:0];
    side_p1.bad        = idx_bad;
    side_p1.last       = issue.last;
    side_p1.grad       = issue.grad;
    side_p1.gpos       = '0;
  end

  always_comb begin
    side_in      = side_p3;
    side_in.gpos = {gpos_z, gpos_y, gpos_x};
  end

  // sideband alongside the axis stages and the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      v_p2 <= 1'b0;
      v_p3 <= 1'b0;
      for (int k = 1; k <= Q_W; k++) v_div[k] <= 1'b0;
    end else if (en) begin
      v_p2     <= v_p1;
      v_p3     <= v_p2;
      v_div[1] <= v_p3;
      for (int k = 2; k <= Q_W; k++) v_div[k] <= v_div[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_p2     <= side_p1;
      side_p3     <= side_p2;
      side_div[1] <= side_in;
      for (int k = 2; k <= Q_W; k++) side_div[k] <= side_div[k-1];
    end
  end

  ggw_div u_div_sx (.clk (clk), .en (en), .num (nsx), .den (dsx), .quo (sx));
  ggw_div u_div_gx (.clk (clk), .en (en), .num (ngx), .den (dgx), .quo (gx));
  ggw_div u_div_sy (.clk (clk), .en (en), .num (nsy), .den (dsy), .quo (sy));
  ggw_div u_div_gy (.clk (clk), .en (en), .num (ngy), .den (dgy), .quo (gy));
  ggw_div u_div_sz (.clk (clk), .en (en), .num (nsz), .den (dsz), .quo (sz));
  ggw_div u_div_gz (.clk (clk), .en (en), .num (ngz), .den (dgz), .quo (gz));

  // product stages
  assign w_full  = {17'b0, ws_m1}  * {34'b0, sz_m1};
  assign tx_full = {17'b0, pxa_m1} * {34'b0, sz_m1};
  assign ty_full = {17'b0, pya_m1} * {34'b0, sz_m1};
  assign tz_full = {17'b0, pza_m1} * {34'b0, sy_m1};
  assign mx_full = {32'b0, tx_m2} * {32'b0, inv_x};
  assign my_full = {32'b0, ty_m2} * {32'b0, inv_y};
  assign mz_full = {32'b0, tz_m2} * {32'b0, inv_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      v_m1     <= 1'b0;
      v_m2     <= 1'b0;
      v_m3     <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v_m1     <= v_div[Q_W];
      v_m2     <= v_m1;
      v_m3     <= v_m2;
      m_tvalid <= v_m3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // pairwise products of weights and slopes
      side_m1 <= side_div[Q_W];
      ws_m1   <= {17'b0, sx} * {17'b0, sy};
      pxa_m1  <= {17'b0, gx} * {17'b0, sy};
      pya_m1  <= {17'b0, gy} * {17'b0, sx};
      pza_m1  <= {17'b0, gz} * {17'b0, sx};
      sy_m1   <= sy;
      sz_m1   <= sz;
      // third factor
      side_m2 <= side_m1;
      w_m2    <= w_full[48:32];
      tx_m2   <= tx_full[47:16];
      ty_m2   <= ty_full[47:16];
      tz_m2   <= tz_full[47:16];
      // scale by inverse cell size
      side_m3 <= side_m2;
      w_m3    <= w_m2;
      mx_m3   <= mx_full[63:32];
      my_m3   <= my_full[63:32];
      mz_m3   <= mz_full[63:32];
      // output register
      out_index  <= side_m3.node_index;
      out_bad    <= side_m3.bad;
      out_weight <= w_m3;
      out_gx     <= fin_grad(mx_m3, side_m3.gpos[0], side_m3.grad);
      out_gy     <= fin_grad(my_m3, side_m3.gpos[1], side_m3.grad);
      out_gz     <= fin_grad(mz_m3, side_m3.gpos[2], side_m3.grad);
      m_tlast    <= side_m3.last;
    end
  end

  assign m_tdata = {6'b0, out_gz, out_gy, out_gx, out_weight, out_bad, out_index};

`ifndef NO_ASSERTIONS
  // no new particle while a result is stalled
  a_no_take_in_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken during output stall");

  // a flagged index reads as zero
  a_bad_index_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_bad) |-> (out_index == '0))
    else $error("bad index not cleared");

  // weight never exceeds one
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_weight <= 17'd65536))
    else $error("weight above one");
`endif

endmodule
`default_nettype wire
